/* rtl/core/dsmb_pkg.sv */
// ----------------------------------------------------------------------------
// dsmb_pkg
// Shared types and constants for the disc stamp / max blend map block.
// ----------------------------------------------------------------------------
package dsmb_pkg;

    localparam int SIDE_W   = 9;
    localparam int CRD_W    = 8;
    localparam int RAD_W    = 9;
    localparam int LVL_W    = 8;
    localparam int NCH_W    = 3;
    localparam int CNT_W    = 17;
    localparam int D_W      = 11;
    localparam int SQ_W     = 20;
    localparam int IDX_W    = 2 * SIDE_W;
    localparam int MIN_SIDE = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [SIDE_W-1:0] SIDE_RST = 9'd256;
    localparam logic [LVL_W-1:0]  LVL_RST  = 8'd255;
    localparam logic [NCH_W-1:0]  NCH_RST  = 3'd2;

    localparam logic [1:0] MODE_STAMP = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    localparam logic [1:0] CFG_MAP_SIDE = 2'd0;
    localparam logic [1:0] CFG_REVEAL   = 2'd1;
    localparam logic [1:0] CFG_CHANNELS = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CRD_W-1:0] center_x;
        logic [CRD_W-1:0] center_y;
        logic [RAD_W-1:0] radius;
        logic [LVL_W-1:0] fill_byte;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0] changed_count;
        logic [LVL_W-1:0] pixel_ch0;
        logic [LVL_W-1:0] pixel_ch1;
        logic [LVL_W-1:0] pixel_ch2;
        logic [LVL_W-1:0] pixel_ch3;
        logic             status;
    } t_out;

    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [LVL_W-1:0]  lvl;
        logic [NCH_W-1:0]  nch;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic res_ready;
    } t_eng_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

/* rtl/core/dsmb_engine.sv */
// ----------------------------------------------------------------------------
// dsmb_engine
// Pixel memory with sequencer: clear/fill sweeps, pixel read, and a disc
// scan that reads, raises and writes back one pixel per cycle.
// ----------------------------------------------------------------------------
module dsmb_engine import dsmb_pkg::*; #(
    parameter int MAX_SIDE       = 256,
    parameter int PIXEL_CHANNELS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in       i_item,
    input  t_cfg      i_cfg,
    input  t_eng_ctl  i_ctl,
    output t_eng_stat o_stat,
    output t_out      o_res
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = LVL_W * PIXEL_CHANNELS;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_SETUP  = 10'b0000000100,
        S_SQUARE = 10'b0000001000,
        S_SCAN   = 10'b0000010000,
        S_DRAIN  = 10'b0000100000,
        S_FILL   = 10'b0001000000,
        S_RADDR  = 10'b0010000000,
        S_RDATA  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [DW-1:0]  r_mem [DEPTH];
    logic [DW-1:0]  r_rdata;

    logic [AW-1:0]     r_sweep;
    logic [CRD_W-1:0]  r_cx, r_cy;
    logic [RAD_W-1:0]  r_rad;
    logic [LVL_W-1:0]  r_fill;
    logic [SIDE_W-1:0] r_r, r_x0, r_x1, r_y0, r_y1, r_x, r_y;
    logic signed [D_W-1:0] r_dx0, r_dy0, r_dx, r_dy;
    logic [SQ_W-1:0]   r_r2, r_dx0sq, r_dx2, r_dy2;
    logic [IDX_W-1:0]  r_row;
    logic              r_p_valid, r_p_in;
    logic [AW-1:0]     r_p_addr;
    logic [CNT_W-1:0]  r_count;
    t_out              r_res;

    logic                  reject;
    logic                  sweep_end;
    logic [SIDE_W-1:0]     side_m1, rad_eff;
    logic signed [D_W-1:0] lo_x, lo_y;
    logic [D_W-1:0]        hi_x, hi_y;
    logic signed [2*D_W-1:0]  sq_dx, sq_dy;
    logic [2*SIDE_W-1:0]   sq_r, row0, rd_row;
    logic [IDX_W-1:0]      scan_idx, rd_idx;
    logic                  in_disc, row_end, last_px;
    logic signed [SQ_W:0]  step_dx2, step_dy2;
    logic [DW-1:0]         new_word;
    logic                  rose, wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [DW-1:0]         wr_data;
    logic [4*LVL_W-1:0]    rd_pad;

    always_comb begin
        reject = ({1'b0, i_item.center_x} >= i_cfg.side) ||
                 ({1'b0, i_item.center_y} >= i_cfg.side);
        sweep_end = (r_sweep == AW'(DEPTH - 1));
        side_m1   = i_cfg.side - 1'b1;

        rad_eff = (r_rad < i_cfg.side) ? r_rad : i_cfg.side;
        lo_x  = $signed(D_W'(r_cx)) - $signed(D_W'(rad_eff));
        lo_y  = $signed(D_W'(r_cy)) - $signed(D_W'(rad_eff));
        hi_x  = D_W'(r_cx) + D_W'(rad_eff);
        hi_y  = D_W'(r_cy) + D_W'(rad_eff);

        sq_dx = (2*D_W)'(r_dx0) * (2*D_W)'(r_dx0);
        sq_dy = (2*D_W)'(r_dy0) * (2*D_W)'(r_dy0);
        sq_r  = (2*SIDE_W)'(r_r) * (2*SIDE_W)'(r_r);
        row0  = (2*SIDE_W)'(r_y0) * (2*SIDE_W)'(i_cfg.side);
        rd_row = (2*SIDE_W)'(r_cy) * (2*SIDE_W)'(i_cfg.side);

        scan_idx = r_row + IDX_W'(r_x);
        rd_idx   = rd_row + IDX_W'(r_cx);
        in_disc  = ({1'b0, r_dx2} + {1'b0, r_dy2}) <= {1'b0, r_r2};
        row_end  = (r_x == r_x1);
        last_px  = row_end && (r_y == r_y1);
        step_dx2 = $signed({1'b0, r_dx2}) + (SQ_W + 1)'($signed({r_dx, 1'b1}));
        step_dy2 = $signed({1'b0, r_dy2}) + (SQ_W + 1)'($signed({r_dy, 1'b1}));
    end

    // raise the channels in use to the reveal level
    always_comb begin
        new_word = r_rdata;
        rose     = 1'b0;
        for (int c = 0; c < PIXEL_CHANNELS; c++) begin
            if ((NCH_W'(c) < i_cfg.nch) && (r_rdata[LVL_W*c +: LVL_W] < i_cfg.lvl)) begin
                new_word[LVL_W*c +: LVL_W] = i_cfg.lvl;
                rose = 1'b1;
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_p_addr;
        wr_data = new_word;
        if ((r_state == S_CLEAR) || (r_state == S_FILL)) begin
            wr_en   = 1'b1;
            wr_addr = r_sweep;
            wr_data = (r_state == S_CLEAR) ? '0 : {PIXEL_CHANNELS{r_fill}};
        end else if (r_p_valid && r_p_in && rose) begin
            wr_en = 1'b1;
        end
        rd_en   = (r_state == S_SCAN) || (r_state == S_RADDR);
        rd_addr = (r_state == S_SCAN) ? AW'(scan_idx) : AW'(rd_idx);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (sweep_end) n_state = S_IDLE;
            S_IDLE: begin
                if (i_ctl.start) begin
                    case (i_item.mode)
                        MODE_STAMP: n_state = reject ? S_DONE : S_SETUP;
                        MODE_READ:  n_state = reject ? S_DONE : S_RADDR;
                        MODE_FILL:  n_state = S_FILL;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP:  n_state = S_SQUARE;
            S_SQUARE: n_state = S_SCAN;
            S_SCAN:   if (last_px) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DONE;
            S_FILL:   if (sweep_end) n_state = S_DONE;
            S_RADDR:  n_state = S_RDATA;
            S_RDATA:  n_state = S_DONE;
            S_DONE:   if (i_ctl.res_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_sweep   <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == S_SCAN);
            if ((r_state == S_CLEAR) || (r_state == S_FILL)) begin
                r_sweep <= r_sweep + 1'b1;
            end else begin
                r_sweep <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_in   <= in_disc;
        r_p_addr <= AW'(scan_idx);

        if (r_p_valid && r_p_in && rose && (r_count != CNT_MAX)) begin
            r_count <= r_count + 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                r_cx    <= i_item.center_x;
                r_cy    <= i_item.center_y;
                r_rad   <= i_item.radius;
                r_fill  <= i_item.fill_byte;
                r_count <= '0;
                r_res.changed_count <= '0;
                r_res.pixel_ch0     <= '0;
                r_res.pixel_ch1     <= '0;
                r_res.pixel_ch2     <= '0;
                r_res.pixel_ch3     <= '0;
                r_res.status <= reject &&
                    ((i_item.mode == MODE_STAMP) || (i_item.mode == MODE_READ));
            end
            S_SETUP: begin
                r_r  <= rad_eff;
                r_x0 <= (lo_x < 0) ? '0 : SIDE_W'(lo_x);
                r_y0 <= (lo_y < 0) ? '0 : SIDE_W'(lo_y);
                r_x1 <= (hi_x > D_W'(side_m1)) ? side_m1 : SIDE_W'(hi_x);
                r_y1 <= (hi_y > D_W'(side_m1)) ? side_m1 : SIDE_W'(hi_y);
                r_dx0 <= (lo_x < 0) ? -$signed(D_W'(r_cx)) : -$signed(D_W'(rad_eff));
                r_dy0 <= (lo_y < 0) ? -$signed(D_W'(r_cy)) : -$signed(D_W'(rad_eff));
            end
            S_SQUARE: begin
                r_r2    <= SQ_W'(sq_r);
                r_dx0sq <= sq_dx[SQ_W-1:0];
                r_dx2   <= sq_dx[SQ_W-1:0];
                r_dy2   <= sq_dy[SQ_W-1:0];
                r_dx    <= r_dx0;
                r_dy    <= r_dy0;
                r_x     <= r_x0;
                r_y     <= r_y0;
                r_row   <= row0;
            end
            S_SCAN: begin
                if (row_end) begin
                    r_x   <= r_x0;
                    r_dx  <= r_dx0;
                    r_dx2 <= r_dx0sq;
                    r_y   <= r_y + 1'b1;
                    r_dy  <= r_dy + 1'b1;
                    r_dy2 <= step_dy2[SQ_W-1:0];
                    r_row <= r_row + IDX_W'(i_cfg.side);
                end else begin
                    r_x   <= r_x + 1'b1;
                    r_dx  <= r_dx + 1'b1;
                    r_dx2 <= step_dx2[SQ_W-1:0];
                end
            end
            S_RDATA: begin
                r_res.pixel_ch0 <= rd_pad[0*LVL_W +: LVL_W];
                r_res.pixel_ch1 <= rd_pad[1*LVL_W +: LVL_W];
                r_res.pixel_ch2 <= rd_pad[2*LVL_W +: LVL_W];
                r_res.pixel_ch3 <= rd_pad[3*LVL_W +: LVL_W];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rd_pad = (4 * LVL_W)'(r_rdata);
        o_res  = r_res;
        o_res.changed_count = r_count;
        o_stat.idle = (r_state == S_IDLE);
        o_stat.done = (r_state == S_DONE) && i_ctl.res_ready;
    end

endmodule

/* rtl/core/disc_stamp_max_blend_top.sv */
// ----------------------------------------------------------------------------
// disc_stamp_max_blend_top
// Square pixel map with filled-disc max-blend stamping, pixel read and fill.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid / o_in_ready / i_in_item       | item in
//  out     | o_out_valid / i_out_ready / o_out_item    | item out
//  cfg     | i_cfg_valid / o_cfg_ready / i_cfg_index,  | register write
//          | i_cfg_data                                |
//
//  Stamp: scans W*H pixels, W*H the clipped bounding square, one pixel per
//  cycle through the memory read/modify/write loop. Read: fetches the centre pixel.
//  Fill: writes all MAX_SIDE*MAX_SIDE entries, one memory entry per cycle.
//  Reset clears all MAX_SIDE*MAX_SIDE memory entries (65536 by default);
//  no item is taken meanwhile, config writes are.
//  The output register holds a result while the next item is accepted.
// ----------------------------------------------------------------------------
module disc_stamp_max_blend_top import dsmb_pkg::*; #(
    parameter int MAX_SIDE       = 256,
    parameter int PIXEL_CHANNELS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [SIDE_W-1:0] i_cfg_data
);

    logic [SIDE_W-1:0] r_map_side;
    logic [LVL_W-1:0]  r_reveal;
    logic [NCH_W-1:0]  r_chan;
    logic              r_out_valid;
    t_out              r_out_item;

    t_cfg      cfg;
    t_eng_ctl  ctl;
    t_eng_stat stat;
    t_out      res;

    always_comb begin
        cfg.side = r_map_side;
        if (r_map_side < SIDE_W'(MIN_SIDE)) begin
            cfg.side = SIDE_W'(MIN_SIDE);
        end else if (32'(r_map_side) > MAX_SIDE) begin
            cfg.side = SIDE_W'(MAX_SIDE);
        end
        cfg.lvl = r_reveal;
        cfg.nch = (32'(r_chan) > PIXEL_CHANNELS) ? NCH_W'(PIXEL_CHANNELS) : r_chan;

        ctl.start     = i_in_valid && stat.idle;
        ctl.res_ready = !r_out_valid || i_out_ready;

        o_in_ready  = stat.idle;
        o_cfg_ready = 1'b1;
        o_out_valid = r_out_valid;
        o_out_item  = r_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_side  <= SIDE_RST;
            r_reveal    <= LVL_RST;
            r_chan      <= NCH_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAP_SIDE: r_map_side <= i_cfg_data;
                    CFG_REVEAL:   r_reveal   <= i_cfg_data[LVL_W-1:0];
                    CFG_CHANNELS: r_chan     <= i_cfg_data[NCH_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (stat.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done) begin
            r_out_item <= res;
        end
    end

    dsmb_engine #(
        .MAX_SIDE       (MAX_SIDE),
        .PIXEL_CHANNELS (PIXEL_CHANNELS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cfg   (cfg),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_res   (res)
    );

endmodule
